// ===== design/mpq_pkg.sv =====
// Shared constants, codes and types for the min priority queue.
package mpq_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = ADDR_W + 2;
  localparam int KEY_W    = 32;
  localparam int ENTRY_W  = 7;
  localparam int EXT_W    = CNT_W + ENTRY_W;

  typedef enum logic [1:0] {
    FUNC_INSERT   = 2'd0,
    FUNC_REMOVE   = 2'd1,
    FUNC_CONTAINS = 2'd2,
    FUNC_CLEAR    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic                    is_empty;
    logic [ENTRY_W-1:0]      entry_count;
    logic signed [KEY_W-1:0] min_key;
    logic signed [KEY_W-1:0] removed_key;
    logic                    found;
    status_t                 status;
  } res_t;

endpackage

// ===== design/mpq_store.sv =====
// Key store: one write port, one read port with registered read data.
module mpq_store (
  input  logic                        clk,
  input  logic                        we,
  input  logic [mpq_pkg::ADDR_W-1:0]  waddr,
  input  logic [mpq_pkg::KEY_W-1:0]   wdata,
  input  logic                        re,
  input  logic [mpq_pkg::ADDR_W-1:0]  raddr,
  output logic [mpq_pkg::KEY_W-1:0]   rdata
);
  import mpq_pkg::*;

  logic [KEY_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/mpq_core.sv =====
// Heap sequencer: sift up, sift down and store scan around one shared comparator.
module mpq_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  mpq_pkg::func_t                   func,
  input  logic signed [mpq_pkg::KEY_W-1:0] key_in,
  output logic                             ready,
  output logic                             res_valid,
  input  logic                             res_ready,
  output mpq_pkg::res_t                    res
);
  import mpq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_UP_RD, S_UP_CMP, S_UP_WR, S_DN_LAST, S_DN_RDL,
    S_DN_RDR, S_DN_CMPR, S_DN_CMP, S_SCAN, S_FIN
  } state_t;

  state_t                  state;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        scan_idx;
  logic                    scan_pend;
  logic [ADDR_W-1:0]       pos;
  logic [ADDR_W-1:0]       best_pos;
  logic signed [KEY_W-1:0] cur;
  logic signed [KEY_W-1:0] best;
  logic signed [KEY_W-1:0] root_key;
  logic signed [KEY_W-1:0] removed;
  status_t                 status;
  logic                    found;

  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_waddr;
  logic [KEY_W-1:0]        mem_wdata;
  logic                    mem_re;
  logic [ADDR_W-1:0]       mem_raddr;
  logic [KEY_W-1:0]        mem_rdata;

  logic signed [KEY_W-1:0] cmp_a;
  logic signed [KEY_W-1:0] cmp_b;
  logic                    lt;
  logic                    eq;

  logic [ADDR_W-1:0]       par_idx;
  logic [IDX_W-1:0]        l_idx;
  logic [IDX_W-1:0]        r_idx;
  logic [IDX_W-1:0]        count_ext;
  logic                    not_full;
  logic [EXT_W-1:0]        count_wide;

  mpq_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign par_idx   = ADDR_W'((pos - 1'b1) >> 1);
  assign l_idx     = IDX_W'({pos, 1'b1});
  assign r_idx     = l_idx + 1'b1;
  assign count_ext = IDX_W'(count);
  assign not_full  = count < CNT_W'(CAPACITY);

  // the one comparator, operands picked by state
  assign lt = cmp_a < cmp_b;
  assign eq = cmp_a == cmp_b;

  always_comb begin
    cmp_a = $signed(mem_rdata);
    cmp_b = cur;
    case (state)
      S_UP_CMP: begin
        cmp_a = cur;
        cmp_b = $signed(mem_rdata);
      end
      S_DN_CMPR: begin
        cmp_a = $signed(mem_rdata);
        cmp_b = best;
      end
      S_DN_CMP: begin
        cmp_a = best;
        cmp_b = cur;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos;
    mem_wdata = cur;
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (state)
      S_IDLE: begin
        if (start && func == FUNC_INSERT && count == '0) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = key_in;
        end else if (start && func == FUNC_REMOVE && count > CNT_W'(1)) begin
          mem_re    = 1'b1;
          mem_raddr = ADDR_W'(count - 1'b1);
        end
      end
      S_UP_RD: begin
        mem_re    = 1'b1;
        mem_raddr = par_idx;
      end
      S_UP_CMP: begin
        mem_we    = 1'b1;
        mem_wdata = lt ? mem_rdata : cur;
      end
      S_UP_WR: begin
        mem_we = 1'b1;
      end
      S_DN_RDL: begin
        if (l_idx >= count_ext) begin
          mem_we = 1'b1;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = l_idx[ADDR_W-1:0];
        end
      end
      S_DN_RDR: begin
        if (r_idx < count_ext) begin
          mem_re    = 1'b1;
          mem_raddr = r_idx[ADDR_W-1:0];
        end
      end
      S_DN_CMP: begin
        mem_we    = 1'b1;
        mem_wdata = lt ? best : cur;
      end
      S_SCAN: begin
        if (scan_idx < count) begin
          mem_re    = 1'b1;
          mem_raddr = scan_idx[ADDR_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      scan_pend <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            cur     <= key_in;
            found   <= 1'b0;
            case (func)
              FUNC_INSERT: begin
                removed <= '0;
                if (!not_full) begin
                  status <= STAT_FULL;
                  state  <= S_FIN;
                end else begin
                  status <= STAT_OK;
                  count  <= count + 1'b1;
                  pos    <= ADDR_W'(count);
                  state  <= (count == '0) ? S_FIN : S_UP_RD;
                end
              end
              FUNC_REMOVE: begin
                if (count == '0) begin
                  status  <= STAT_EMPTY;
                  removed <= '0;
                  state   <= S_FIN;
                end else begin
                  status  <= STAT_OK;
                  removed <= root_key;
                  count   <= count - 1'b1;
                  state   <= (count == CNT_W'(1)) ? S_FIN : S_DN_LAST;
                end
              end
              FUNC_CONTAINS: begin
                status    <= STAT_OK;
                removed   <= '0;
                scan_idx  <= '0;
                scan_pend <= 1'b0;
                state     <= S_SCAN;
              end
              default: begin
                status  <= STAT_OK;
                removed <= '0;
                count   <= '0;
                state   <= S_FIN;
              end
            endcase
          end
        end
        S_UP_RD: state <= S_UP_CMP;
        S_UP_CMP: begin
          if (lt) begin
            pos   <= par_idx;
            state <= (par_idx == '0) ? S_UP_WR : S_UP_RD;
          end else begin
            state <= S_FIN;
          end
        end
        S_UP_WR: state <= S_FIN;
        S_DN_LAST: begin
          // last entry fills the hole at the root
          cur   <= $signed(mem_rdata);
          pos   <= '0;
          state <= S_DN_RDL;
        end
        S_DN_RDL: state <= (l_idx >= count_ext) ? S_FIN : S_DN_RDR;
        S_DN_RDR: begin
          best     <= $signed(mem_rdata);
          best_pos <= l_idx[ADDR_W-1:0];
          state    <= (r_idx < count_ext) ? S_DN_CMPR : S_DN_CMP;
        end
        S_DN_CMPR: begin
          // right child wins only when strictly smaller
          if (lt) begin
            best     <= $signed(mem_rdata);
            best_pos <= r_idx[ADDR_W-1:0];
          end
          state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (lt) begin
            pos   <= best_pos;
            state <= S_DN_RDL;
          end else begin
            state <= S_FIN;
          end
        end
        S_SCAN: begin
          if (scan_idx < count) begin
            scan_idx  <= scan_idx + 1'b1;
            scan_pend <= 1'b1;
          end else begin
            scan_pend <= 1'b0;
          end
          if (scan_pend && eq) begin
            found <= 1'b1;
          end
          if (!(scan_idx < count) && !scan_pend) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // mirror of entry zero for the minimum output
  always_ff @(posedge clk) begin
    if (mem_we && mem_waddr == '0) begin
      root_key <= $signed(mem_wdata);
    end
  end

  assign count_wide = EXT_W'(count);
  assign ready      = (state == S_IDLE);
  assign res_valid  = (state == S_FIN);

  always_comb begin
    res.status      = status;
    res.found       = found;
    res.removed_key = removed;
    res.min_key     = (count == '0) ? '0 : root_key;
    res.entry_count = count_wide[ENTRY_W-1:0];
    res.is_empty    = (count == '0);
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // the first key into an empty queue is written before the count moves
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> ((CNT_W'(mem_waddr) < count) || (state == S_IDLE && count == '0)))
    else $error("store write outside live entries");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    (start && ready && func == FUNC_CLEAR) |=> (count == '0))
    else $error("clear left entries");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (start && ready && func == FUNC_INSERT && not_full) |=> (count == $past(count) + 1'b1))
    else $error("insert did not add an entry");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (mem_we && state == S_IDLE) |-> (start && func == FUNC_INSERT))
    else $error("store write while idle");

endmodule

// ===== design/min_priority_queue.sv =====
// Top level: input handshake, heap sequencer and output word register.
//
//  channel  | dir | fields (low bit first)
//  ---------+-----+------------------------------------------------------------
//  s_*      | in  | tuser: func[1:0]; tdata: key_in[31:0]
//  m_*      | out | tdata: status, found, removed_key, min_key, entry_count,
//           |     |        is_empty, zero pad
//
//  Clear, a refused insert, the first insert and removal from a queue of one or none go
//  straight to the result. Insert sifts up level by level and ends early when the key
//  reaches the root; remove sifts down level by level and may stop above the leaves. A
//  contains query reads every live entry.
//  Synchronous reset empties the queue; store contents are not cleared.
//  The result cycle repeats while the output register is full; a new word is taken
//  while the previous result waits in the output register.
module min_priority_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // key_in[31:0]
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata    // status[1:0], found[2], removed_key[34:3],
                                 // min_key[66:35], entry_count[73:67],
                                 // is_empty[74], zero[79:75]
);
  import mpq_pkg::*;

  logic core_ready;
  logic res_valid;
  logic res_ready;
  res_t res;

  mpq_core u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (s_tvalid && core_ready),
    .func      (func_t'(s_tuser)),
    .key_in    ($signed(s_tdata)),
    .ready     (core_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign s_tready  = core_ready;
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {5'd0, res.is_empty, res.entry_count, res.min_key,
                  res.removed_key, res.found, res.status};
    end
  end

endmodule

// ===== sim/min_priority_queue_tb.sv =====
// Self-checking testbench for the min priority queue: random and directed operations.
module min_priority_queue_tb;
  import mpq_pkg::*;

  typedef struct {
    func_t             f;
    logic signed [31:0] k;
    bit                 sync;   // hold off until every outstanding result is back
  } op_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;

  op_t                pending_ops[$];
  op_t                cur_op;
  res_t               expected_words[$];
  logic signed [31:0] held_keys[$];    // multiset of keys the queue should hold
  logic signed [31:0] recent_keys[$];  // inserted keys reused for queries
  int                 fill_level;
  int                 n_sent = 0;
  int                 n_got = 0;
  int                 errors = 0;
  int                 n_func[4] = '{0, 0, 0, 0};
  int                 n_full = 0;
  int                 n_empty_rm = 0;
  int                 n_hit = 0;

  min_priority_queue DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int smallest_index();
    int lo;
    lo = 0;
    foreach (held_keys[i])
      if (held_keys[i] < held_keys[lo]) lo = i;
    return lo;
  endfunction

  // Apply one operation to the key multiset and return the word it should produce.
  function automatic res_t queue_result(func_t f, logic signed [31:0] k);
    res_t r;
    int   lo;
    r = '0;
    r.status = STAT_OK;
    case (f)
      FUNC_INSERT: begin
        if (held_keys.size() >= CAPACITY) r.status = STAT_FULL;
        else held_keys.push_back(k);
      end
      FUNC_REMOVE: begin
        if (held_keys.size() == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          lo = smallest_index();
          r.removed_key = held_keys[lo];
          held_keys.delete(lo);
        end
      end
      FUNC_CONTAINS: begin
        foreach (held_keys[i])
          if (held_keys[i] == k) r.found = 1'b1;
      end
      default: held_keys.delete();
    endcase
    if (held_keys.size() > 0) r.min_key = held_keys[smallest_index()];
    r.entry_count = ENTRY_W'(held_keys.size());
    r.is_empty = (held_keys.size() == 0);
    return r;
  endfunction

  function automatic logic signed [31:0] pick_key();
    int c;
    c = $urandom_range(0, 9);
    case (c)
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 32'sd0;
          3: return -32'sd1;
          default: return 32'sd1;
        endcase
      end
      1, 2, 3: return $signed(32'($urandom_range(0, 40))) - 32'sd20;
      4, 5: if (recent_keys.size() > 0)
              return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
      default: ;
    endcase
    return $signed($urandom());
  endfunction

  task automatic add_op(func_t f, logic signed [31:0] k, bit sync);
    op_t o;
    o.f = f;
    o.k = k;
    o.sync = sync;
    pending_ops.push_back(o);
    case (f)
      FUNC_INSERT: begin
        if (fill_level < CAPACITY) fill_level++;
        recent_keys.push_back(k);
        if (recent_keys.size() > 32) void'(recent_keys.pop_front());
      end
      FUNC_REMOVE: if (fill_level > 0) fill_level--;
      FUNC_CLEAR:  fill_level = 0;
      default: ;
    endcase
  endtask

  // Phase kinds: 0 fill, 1 drain, 2 mixed, 3 noise (uniform, frequent clears).
  function automatic func_t pick_func(int kind);
    int r;
    r = $urandom_range(0, 99);
    case (kind)
      0: begin
        if (r < 78) return FUNC_INSERT;
        if (r < 88) return FUNC_REMOVE;
        if (r < 99) return FUNC_CONTAINS;
        return FUNC_CLEAR;
      end
      1: begin
        if (r < 72) return FUNC_REMOVE;
        if (r < 87) return FUNC_INSERT;
        if (r < 99) return FUNC_CONTAINS;
        return FUNC_CLEAR;
      end
      2: begin
        if (r < 45) return FUNC_INSERT;
        if (r < 80) return FUNC_REMOVE;
        if (r < 98) return FUNC_CONTAINS;
        return FUNC_CLEAR;
      end
      default: return func_t'(r % 4);
    endcase
  endfunction

  // Driver: presents the pending words, predicts each accepted one.
  always @(posedge clk) begin : driver
    bit quiet;
    bit idle_now;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_words.push_back(queue_result(cur_op.f, cur_op.k));
        n_func[cur_op.f]++;
        n_sent++;
        if (expected_words[$].status == STAT_FULL) n_full++;
        if (expected_words[$].status == STAT_EMPTY) n_empty_rm++;
        if (expected_words[$].found) n_hit++;
      end
      if (!s_tvalid || s_tready) begin
        quiet = (n_sent >= 600 && n_sent < 800);
        idle_now = !quiet && ($urandom_range(0, 99) < 38);
        if (pending_ops.size() > 0 && !idle_now &&
            !(pending_ops[0].sync && expected_words.size() > 0)) begin
          cur_op = pending_ops.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= cur_op.k;
          s_tuser  <= cur_op.f;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Monitor: compares every result word with the oldest prediction.
  always @(posedge clk) begin : monitor
    res_t got;
    res_t want;
    bit   quiet;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[74:0];
        n_got++;
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %0h", $time, m_tdata);
          errors++;
        end else begin
          want = expected_words.pop_front();
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("found", 32'(want.found), 32'(got.found));
          check_field("removed_key", want.removed_key, got.removed_key);
          check_field("min_key", want.min_key, got.min_key);
          check_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
          check_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
          check_field("pad", 32'd0, 32'(m_tdata[79:75]));
        end
      end
      quiet = (n_got >= 300 && n_got < 500);
      m_tready <= quiet || ($urandom_range(0, 99) >= 38);
    end
  end

  initial begin : stimulus
    int kind;
    int len;
    fill_level = 0;

    // directed: empty-queue cases, key extremes, duplicates, hit and miss, clear
    add_op(FUNC_REMOVE,   32'sd0, 1'b0);
    add_op(FUNC_CONTAINS, 32'sd0, 1'b0);
    add_op(FUNC_CLEAR,    32'sd0, 1'b0);
    add_op(FUNC_INSERT,   32'sh7fff_ffff, 1'b0);
    add_op(FUNC_INSERT,   32'sh8000_0000, 1'b0);
    add_op(FUNC_INSERT,   32'sd0, 1'b0);
    add_op(FUNC_INSERT,   -32'sd1, 1'b0);
    add_op(FUNC_INSERT,   -32'sd1, 1'b0);
    add_op(FUNC_CONTAINS, 32'sh7fff_ffff, 1'b0);
    add_op(FUNC_CONTAINS, 32'sd1, 1'b0);
    add_op(FUNC_CONTAINS, 32'sh8000_0000, 1'b0);
    add_op(FUNC_REMOVE,   32'sd0, 1'b0);
    add_op(FUNC_REMOVE,   32'sd0, 1'b0);
    add_op(FUNC_REMOVE,   32'sd0, 1'b0);
    add_op(FUNC_CONTAINS, -32'sd1, 1'b0);
    add_op(FUNC_INSERT,   32'sd5, 1'b0);
    add_op(FUNC_CLEAR,    32'sd0, 1'b0);
    add_op(FUNC_REMOVE,   32'sd0, 1'b0);
    add_op(FUNC_INSERT,   32'sd123, 1'b0);
    add_op(FUNC_CONTAINS, 32'sd123, 1'b0);
    add_op(FUNC_REMOVE,   32'sd0, 1'b0);

    // fill to capacity, then a few inserts that must be refused
    while (fill_level < CAPACITY)
      add_op(FUNC_INSERT, pick_key(), 1'b0);
    repeat (3) add_op(FUNC_INSERT, pick_key(), 1'b0);

    // random: first a long fill phase starting from the full queue, then phases of all kinds
    kind = 0;
    len = 80;
    while (pending_ops.size() < 1220) begin
      for (int i = 0; i < len; i++)
        add_op(pick_func(kind), pick_key(), i == 0 && (kind == 0 || $urandom_range(0, 2) == 0));
      kind = $urandom_range(0, 3);
      len = (kind == 0) ? $urandom_range(50, 110) : $urandom_range(15, 80);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (pending_ops.size() > 0 || s_tvalid || expected_words.size() > 0);
    repeat (200) @(posedge clk);

    $display("Ran %0d inserts, %0d removals, %0d queries, %0d clears; %0d words checked.",
             n_func[FUNC_INSERT], n_func[FUNC_REMOVE], n_func[FUNC_CONTAINS],
             n_func[FUNC_CLEAR], n_got);
    $display("Inserts refused when full: %0d, removals from empty: %0d, query hits: %0d.",
             n_full, n_empty_rm, n_hit);
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
